/* hw/rtl/ffa_pkg.sv */
// Shared types and codes of the first-fit heap allocator.
// No dependencies; used by ffa_dp, ffa_ctrl and the top level.
package ffa_pkg;

	// result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_NOFIT = 2'd1;
	localparam status_t ST_BAD   = 2'd2;

	// request codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// heap word address select
	typedef logic [2:0] asel_t;
	localparam asel_t AS_CUR   = 3'd0;
	localparam asel_t AS_CUR8  = 3'd1;
	localparam asel_t AS_REM   = 3'd2;
	localparam asel_t AS_REM8  = 3'd3;
	localparam asel_t AS_PREV8 = 3'd4;
	localparam asel_t AS_NXT   = 3'd5;
	localparam asel_t AS_NXT8  = 3'd6;

	// heap word write data select
	typedef logic [2:0] dsel_t;
	localparam dsel_t DS_REMSZ = 3'd0;
	localparam dsel_t DS_NXT   = 3'd1;
	localparam dsel_t DS_REM   = 3'd2;
	localparam dsel_t DS_REQ   = 3'd3;
	localparam dsel_t DS_MAGIC = 3'd4;
	localparam dsel_t DS_HEAD  = 3'd5;
	localparam dsel_t DS_SUM   = 3'd6;
	localparam dsel_t DS_RDATA = 3'd7;

	// datapath register operations
	typedef logic [3:0] op_t;
	localparam op_t OP_NONE     = 4'd0;
	localparam op_t OP_START    = 4'd1;
	localparam op_t OP_LD_SZ    = 4'd2;
	localparam op_t OP_LD_NXT   = 4'd3;
	localparam op_t OP_ADVANCE  = 4'd4;
	localparam op_t OP_ALLOC_OK = 4'd5;
	localparam op_t OP_NOFIT    = 4'd6;
	localparam op_t OP_BAD      = 4'd7;
	localparam op_t OP_FREE_ACC = 4'd8;
	localparam op_t OP_SZ_HDR   = 4'd9;
	localparam op_t OP_MERGE    = 4'd10;
	localparam op_t OP_FREE_OK  = 4'd11;
	localparam op_t OP_PUBLISH  = 4'd12;

	// controller to datapath
	typedef struct packed {
		logic  go;
		logic  wr;
		asel_t asel;
		dsel_t dsel;
		op_t   op;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic init_done;
		logic mem_done;
		logic is_free;
		logic walk_end;
		logic fit;
		logic prev_end;
		logic addr_small;
		logic magic_bad;
		logic size_bad;
		logic step_end;
		logic nxt_end;
		logic adjacent;
	} sts_t;

	localparam logic [63:0] MAGIC_RESET = 64'd1234567;

endpackage

/* hw/rtl/ffa_mem.sv */
// Heap byte store with a byte-serial 64-bit little-endian word access engine
// and the clearing pass after reset. No package dependency.
module ffa_mem #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 16,
	parameter int AW           = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic          wr,
	input  logic [AW-1:0] addr,
	input  logic [63:0]   wdata,
	output logic          done,
	output logic [63:0]   rdata,
	output logic          init_done
);

	localparam int HW = $clog2(HEAP_BYTES);
	localparam logic [63:0] ROOT_SIZE = 64'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [HW-1:0] LAST_IDX = HW'(HEAP_BYTES - 1);

	logic [7:0]    heap_q [HEAP_BYTES];
	logic [HW-1:0] clr_q;
	logic          init_done_q;
	logic          busy_q;
	logic          wr_q;
	logic [2:0]    idx_q;
	logic          done_q;
	logic          cap_s1;
	logic [2:0]    lane_s1;
	logic          inr_s1;
	logic [7:0]    byte_s1;
	logic [AW-1:0] base_q;
	logic [63:0]   wdata_q;
	logic [63:0]   rdata_q;
	logic [AW-1:0] baddr;
	logic          in_rng;
	logic          we;
	logic [HW-1:0] widx;
	logic [7:0]    wbyte;

	// byte of the heap image after reset: one node spanning the heap
	function automatic logic [7:0] root_byte(input logic [HW-1:0] a);
		logic [7:0] b;
		b = 8'h00;
		if (32'(a) < 32'd8)
			b = ROOT_SIZE[8*a[2:0] +: 8];
		else if (32'(a) < 32'd16)
			b = 8'hFF;
		return b;
	endfunction

	// current byte address; bytes beyond the heap read zero, writes dropped
	assign baddr  = base_q + AW'(idx_q);
	assign in_rng = 32'(baddr) < 32'(HEAP_BYTES);

	always_comb begin
		if (!init_done_q) begin
			we    = 1'b1;
			widx  = clr_q;
			wbyte = root_byte(clr_q);
		end else begin
			we    = busy_q && wr_q && in_rng;
			widx  = baddr[HW-1:0];
			wbyte = wdata_q[8*idx_q +: 8];
		end
	end

	// byte array, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we)
			heap_q[widx] <= wbyte;
		byte_s1 <= heap_q[baddr[HW-1:0]];
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			init_done_q <= 1'b0;
			busy_q      <= 1'b0;
			wr_q        <= 1'b0;
			idx_q       <= 3'd0;
			done_q      <= 1'b0;
			cap_s1      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!init_done_q) begin
				clr_q <= clr_q + HW'(1);
				if (clr_q == LAST_IDX)
					init_done_q <= 1'b1;
			end
			if (go) begin
				busy_q <= 1'b1;
				wr_q   <= wr;
				idx_q  <= 3'd0;
			end else if (busy_q) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					busy_q <= 1'b0;
					if (wr_q)
						done_q <= 1'b1;
				end
			end
			cap_s1 <= busy_q && !wr_q;
			if (cap_s1 && lane_s1 == 3'd7)
				done_q <= 1'b1;
		end
	end

	// word registers
	always_ff @(posedge clk) begin
		if (go) begin
			base_q  <= addr;
			wdata_q <= wdata;
		end
		lane_s1 <= idx_q;
		inr_s1  <= in_rng;
		if (cap_s1)
			rdata_q[8*lane_s1 +: 8] <= inr_s1 ? byte_s1 : 8'h00;
	end

	assign done      = done_q;
	assign rdata     = rdata_q;
	assign init_done = init_done_q;

	ap_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (init_done_q && !busy_q))
		else $error("word access started while engine busy or clearing");

	ap_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("word access completion held over two cycles");

endmodule

/* hw/rtl/ffa_dp.sv */
// Allocator datapath: list pointers, running counts, magic register, result
// registers and the heap store. Depends on ffa_pkg and ffa_mem.
module ffa_dp #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 16,
	parameter int AW           = 15,
	parameter int SW           = 9
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ffa_pkg::ctl_t   ctl,
	output ffa_pkg::sts_t   sts,
	input  logic            cmd,
	input  logic [12:0]     request_size,
	input  logic [11:0]     block_addr,
	input  logic            cfg_we,
	input  logic [63:0]     cfg_wdata,
	output logic [11:0]     payload_offset,
	output ffa_pkg::status_t status,
	output logic [12:0]     free_bytes,
	output logic [8:0]      free_nodes
);

	localparam logic [63:0] HEAP_W = 64'(HEAP_BYTES);
	localparam logic [63:0] HDR_W  = 64'(HEADER_BYTES);
	localparam int LIMIT = HEAP_BYTES / HEADER_BYTES + 1;

	// control state
	logic [AW-1:0] head_q;
	logic [63:0]   fbc_q;
	logic [63:0]   fnc_q;
	logic [63:0]   magic_q;
	logic [SW-1:0] steps_q;
	logic          cur_end_q;
	logic          prev_end_q;
	// item registers
	logic          cmd_q;
	logic [12:0]   req_q;
	logic [11:0]   addr_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] prev_q;
	logic [63:0]   sz_q;
	logic [63:0]   nxt_q;
	logic [11:0]   res_payload_q;
	ffa_pkg::status_t res_status_q;
	logic [11:0]   out_payload_q;
	ffa_pkg::status_t out_status_q;
	logic [12:0]   out_fb_q;
	logic [8:0]    out_fn_q;

	logic [AW-1:0] need;
	logic [AW-1:0] rem;
	logic [AW-1:0] mem_addr;
	logic [63:0]   mem_wdata;
	logic [63:0]   mem_rdata;
	logic          mem_done;
	logic          init_done;

	assign need = AW'(req_q) + AW'(HEADER_BYTES);
	assign rem  = cur_q + need;

	// word address select
	always_comb begin
		case (ctl.asel)
			ffa_pkg::AS_CUR:   mem_addr = cur_q;
			ffa_pkg::AS_CUR8:  mem_addr = cur_q + AW'(8);
			ffa_pkg::AS_REM:   mem_addr = rem;
			ffa_pkg::AS_REM8:  mem_addr = rem + AW'(8);
			ffa_pkg::AS_PREV8: mem_addr = prev_q + AW'(8);
			ffa_pkg::AS_NXT:   mem_addr = nxt_q[AW-1:0];
			ffa_pkg::AS_NXT8:  mem_addr = nxt_q[AW-1:0] + AW'(8);
			default:           mem_addr = cur_q;
		endcase
	end

	// write data select
	always_comb begin
		case (ctl.dsel)
			ffa_pkg::DS_REMSZ: mem_wdata = sz_q - 64'(need);
			ffa_pkg::DS_NXT:   mem_wdata = nxt_q;
			ffa_pkg::DS_REM:   mem_wdata = 64'(rem);
			ffa_pkg::DS_REQ:   mem_wdata = 64'(req_q);
			ffa_pkg::DS_MAGIC: mem_wdata = magic_q;
			ffa_pkg::DS_HEAD:  mem_wdata = 64'(head_q);
			ffa_pkg::DS_SUM:   mem_wdata = sz_q + mem_rdata;
			ffa_pkg::DS_RDATA: mem_wdata = mem_rdata;
			default:           mem_wdata = mem_rdata;
		endcase
	end

	ffa_mem #(
		.HEAP_BYTES  (HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.AW          (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (ctl.go),
		.wr       (ctl.wr),
		.addr     (mem_addr),
		.wdata    (mem_wdata),
		.done     (mem_done),
		.rdata    (mem_rdata),
		.init_done(init_done)
	);

	// status back to the controller
	always_comb begin
		sts.init_done  = init_done;
		sts.mem_done   = mem_done;
		sts.is_free    = (cmd_q == ffa_pkg::CMD_FREE);
		sts.step_end   = (32'(steps_q) >= 32'(LIMIT));
		sts.walk_end   = cur_end_q || sts.step_end;
		sts.fit        = (sz_q >= 64'(need));
		sts.prev_end   = prev_end_q;
		sts.addr_small = (32'(addr_q) < 32'(HEADER_BYTES));
		sts.magic_bad  = (nxt_q != magic_q);
		sts.size_bad   = (32'(addr_q) > 32'(HEAP_BYTES)) ||
			(sz_q > (HEAP_W - 64'(addr_q)));
		sts.nxt_end    = (nxt_q >= HEAP_W);
		sts.adjacent   = (nxt_q == sz_q + 64'(cur_q) + HDR_W);
	end

	// list head, counts and magic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			fbc_q      <= HEAP_W - HDR_W;
			fnc_q      <= 64'd1;
			magic_q    <= ffa_pkg::MAGIC_RESET;
			steps_q    <= '0;
			cur_end_q  <= 1'b0;
			prev_end_q <= 1'b1;
		end else begin
			if (cfg_we)
				magic_q <= cfg_wdata;
			case (ctl.op)
				ffa_pkg::OP_START: begin
					steps_q    <= '0;
					prev_end_q <= 1'b1;
					cur_end_q  <= (cmd == ffa_pkg::CMD_ALLOC) &&
						(32'(head_q) >= 32'(HEAP_BYTES));
				end
				ffa_pkg::OP_ADVANCE: begin
					prev_end_q <= 1'b0;
					cur_end_q  <= (nxt_q >= HEAP_W);
					steps_q    <= steps_q + SW'(1);
				end
				ffa_pkg::OP_ALLOC_OK: begin
					if (prev_end_q)
						head_q <= rem;
					fbc_q <= (fbc_q > 64'(need)) ? fbc_q - 64'(need) : 64'd0;
				end
				ffa_pkg::OP_FREE_ACC: begin
					fbc_q   <= fbc_q + sz_q;
					fnc_q   <= fnc_q + 64'd1;
					steps_q <= '0;
				end
				ffa_pkg::OP_MERGE: begin
					fbc_q   <= fbc_q + HDR_W;
					fnc_q   <= (fnc_q > 64'd1) ? fnc_q - 64'd1 : 64'd0;
					steps_q <= steps_q + SW'(1);
				end
				ffa_pkg::OP_FREE_OK: head_q <= cur_q;
				default: ;
			endcase
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		case (ctl.op)
			ffa_pkg::OP_START: begin
				cmd_q  <= cmd;
				req_q  <= request_size;
				addr_q <= block_addr;
				cur_q  <= (cmd == ffa_pkg::CMD_ALLOC) ? head_q :
					AW'(block_addr) - AW'(HEADER_BYTES);
			end
			ffa_pkg::OP_LD_SZ:  sz_q  <= mem_rdata;
			ffa_pkg::OP_LD_NXT: nxt_q <= mem_rdata;
			ffa_pkg::OP_ADVANCE: begin
				prev_q <= cur_q;
				cur_q  <= nxt_q[AW-1:0];
			end
			ffa_pkg::OP_ALLOC_OK: begin
				res_payload_q <= 12'(cur_q + AW'(HEADER_BYTES));
				res_status_q  <= ffa_pkg::ST_OK;
			end
			ffa_pkg::OP_NOFIT: begin
				res_payload_q <= 12'd0;
				res_status_q  <= ffa_pkg::ST_NOFIT;
			end
			ffa_pkg::OP_BAD: begin
				res_payload_q <= 12'd0;
				res_status_q  <= ffa_pkg::ST_BAD;
			end
			ffa_pkg::OP_SZ_HDR: sz_q <= sz_q + HDR_W;
			ffa_pkg::OP_FREE_OK: begin
				res_payload_q <= 12'd0;
				res_status_q  <= ffa_pkg::ST_OK;
			end
			ffa_pkg::OP_PUBLISH: begin
				out_payload_q <= res_payload_q;
				out_status_q  <= res_status_q;
				out_fb_q      <= fbc_q[12:0];
				out_fn_q      <= fnc_q[8:0];
			end
			default: ;
		endcase
	end

	assign payload_offset = out_payload_q;
	assign status         = out_status_q;
	assign free_bytes     = out_fb_q;
	assign free_nodes     = out_fn_q;

endmodule

/* hw/rtl/ffa_ctrl.sv */
// Allocator controller: sequences list walk, split, free and forward merge,
// and owns the request and result handshakes. Depends on ffa_pkg.
module ffa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ffa_pkg::sts_t sts,
	output ffa_pkg::ctl_t ctl
);

	localparam logic [4:0] S_INIT   = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_DISP   = 5'd2;
	localparam logic [4:0] S_PUB    = 5'd3;
	localparam logic [4:0] S_A_CHK  = 5'd4;
	localparam logic [4:0] S_A_RSZ  = 5'd5;
	localparam logic [4:0] S_A_RNX  = 5'd6;
	localparam logic [4:0] S_A_DEC  = 5'd7;
	localparam logic [4:0] S_A_W1   = 5'd8;
	localparam logic [4:0] S_A_W2   = 5'd9;
	localparam logic [4:0] S_A_W3   = 5'd10;
	localparam logic [4:0] S_A_W4   = 5'd11;
	localparam logic [4:0] S_A_W5   = 5'd12;
	localparam logic [4:0] S_F_CHK  = 5'd13;
	localparam logic [4:0] S_F_RMG  = 5'd14;
	localparam logic [4:0] S_F_CMG  = 5'd15;
	localparam logic [4:0] S_F_RSZ  = 5'd16;
	localparam logic [4:0] S_F_CSZ  = 5'd17;
	localparam logic [4:0] S_F_WH   = 5'd18;
	localparam logic [4:0] S_M_CHK  = 5'd19;
	localparam logic [4:0] S_M_RNX  = 5'd20;
	localparam logic [4:0] S_M_CNX  = 5'd21;
	localparam logic [4:0] S_M_RSZ  = 5'd22;
	localparam logic [4:0] S_M_CADJ = 5'd23;
	localparam logic [4:0] S_M_RN   = 5'd24;
	localparam logic [4:0] S_M_WS   = 5'd25;
	localparam logic [4:0] S_M_RN8  = 5'd26;
	localparam logic [4:0] S_M_WN   = 5'd27;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       pend_q;
	logic       out_valid_q;
	logic       acc;
	logic       acc_done;
	logic       out_free;

	assign acc_done = pend_q && sts.mem_done;
	assign out_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		acc      = 1'b0;
		ctl      = '0;
		ctl.asel = ffa_pkg::AS_CUR;
		ctl.dsel = ffa_pkg::DS_RDATA;
		ctl.op   = ffa_pkg::OP_NONE;
		case (state_q)
			S_INIT: if (sts.init_done) state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					ctl.op  = ffa_pkg::OP_START;
					state_d = S_DISP;
				end
			end
			S_DISP: state_d = sts.is_free ? S_F_CHK : S_A_CHK;
			S_PUB: begin
				if (out_free) begin
					ctl.op  = ffa_pkg::OP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			// allocate: first-fit walk
			S_A_CHK: begin
				if (sts.walk_end) begin
					ctl.op  = ffa_pkg::OP_NOFIT;
					state_d = S_PUB;
				end else begin
					state_d = S_A_RSZ;
				end
			end
			S_A_RSZ: begin
				acc = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_LD_SZ;
					state_d = S_A_RNX;
				end
			end
			S_A_RNX: begin
				acc = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR8;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_LD_NXT;
					state_d = S_A_DEC;
				end
			end
			S_A_DEC: begin
				if (sts.fit) begin
					state_d = S_A_W1;
				end else begin
					ctl.op  = ffa_pkg::OP_ADVANCE;
					state_d = S_A_CHK;
				end
			end
			// split: remainder node, relink, allocated header
			S_A_W1: begin
				acc = 1'b1;
				ctl.wr   = 1'b1;
				ctl.asel = ffa_pkg::AS_REM;
				ctl.dsel = ffa_pkg::DS_REMSZ;
				if (acc_done) state_d = S_A_W2;
			end
			S_A_W2: begin
				acc = 1'b1;
				ctl.wr   = 1'b1;
				ctl.asel = ffa_pkg::AS_REM8;
				ctl.dsel = ffa_pkg::DS_NXT;
				if (acc_done) state_d = S_A_W3;
			end
			S_A_W3: begin
				if (sts.prev_end) begin
					state_d = S_A_W4;
				end else begin
					acc = 1'b1;
					ctl.wr   = 1'b1;
					ctl.asel = ffa_pkg::AS_PREV8;
					ctl.dsel = ffa_pkg::DS_REM;
					if (acc_done) state_d = S_A_W4;
				end
			end
			S_A_W4: begin
				acc = 1'b1;
				ctl.wr   = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR;
				ctl.dsel = ffa_pkg::DS_REQ;
				if (acc_done) state_d = S_A_W5;
			end
			S_A_W5: begin
				acc = 1'b1;
				ctl.wr   = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR8;
				ctl.dsel = ffa_pkg::DS_MAGIC;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_ALLOC_OK;
					state_d = S_PUB;
				end
			end
			// free: checks and push at head
			S_F_CHK: begin
				if (sts.addr_small) begin
					ctl.op  = ffa_pkg::OP_BAD;
					state_d = S_PUB;
				end else begin
					state_d = S_F_RMG;
				end
			end
			S_F_RMG: begin
				acc = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR8;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_LD_NXT;
					state_d = S_F_CMG;
				end
			end
			S_F_CMG: begin
				if (sts.magic_bad) begin
					ctl.op  = ffa_pkg::OP_BAD;
					state_d = S_PUB;
				end else begin
					state_d = S_F_RSZ;
				end
			end
			S_F_RSZ: begin
				acc = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_LD_SZ;
					state_d = S_F_CSZ;
				end
			end
			S_F_CSZ: begin
				if (sts.size_bad) begin
					ctl.op  = ffa_pkg::OP_BAD;
					state_d = S_PUB;
				end else begin
					state_d = S_F_WH;
				end
			end
			S_F_WH: begin
				acc = 1'b1;
				ctl.wr   = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR8;
				ctl.dsel = ffa_pkg::DS_HEAD;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_FREE_ACC;
					state_d = S_M_CHK;
				end
			end
			// free: merge forward with adjacent successors
			S_M_CHK: begin
				if (sts.step_end) begin
					ctl.op  = ffa_pkg::OP_FREE_OK;
					state_d = S_PUB;
				end else begin
					state_d = S_M_RNX;
				end
			end
			S_M_RNX: begin
				acc = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR8;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_LD_NXT;
					state_d = S_M_CNX;
				end
			end
			S_M_CNX: begin
				if (sts.nxt_end) begin
					ctl.op  = ffa_pkg::OP_FREE_OK;
					state_d = S_PUB;
				end else begin
					state_d = S_M_RSZ;
				end
			end
			S_M_RSZ: begin
				acc = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_LD_SZ;
					state_d = S_M_CADJ;
				end
			end
			S_M_CADJ: begin
				if (!sts.adjacent) begin
					ctl.op  = ffa_pkg::OP_FREE_OK;
					state_d = S_PUB;
				end else begin
					ctl.op  = ffa_pkg::OP_SZ_HDR;
					state_d = S_M_RN;
				end
			end
			S_M_RN: begin
				acc = 1'b1;
				ctl.asel = ffa_pkg::AS_NXT;
				if (acc_done) state_d = S_M_WS;
			end
			S_M_WS: begin
				acc = 1'b1;
				ctl.wr   = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR;
				ctl.dsel = ffa_pkg::DS_SUM;
				if (acc_done) state_d = S_M_RN8;
			end
			S_M_RN8: begin
				acc = 1'b1;
				ctl.asel = ffa_pkg::AS_NXT8;
				if (acc_done) state_d = S_M_WN;
			end
			S_M_WN: begin
				acc = 1'b1;
				ctl.wr   = 1'b1;
				ctl.asel = ffa_pkg::AS_CUR8;
				ctl.dsel = ffa_pkg::DS_RDATA;
				if (acc_done) begin
					ctl.op  = ffa_pkg::OP_MERGE;
					state_d = S_M_CHK;
				end
			end
			default: state_d = S_INIT;
		endcase
		// launch the word access once per access state
		ctl.go = acc && !pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.go)
				pend_q <= 1'b1;
			else if (acc_done)
				pend_q <= 1'b0;
			if (ctl.op == ffa_pkg::OP_PUBLISH)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	ap_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mem_done |-> pend_q)
		else $error("word access completed with none outstanding");

	ap_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == ffa_pkg::OP_PUBLISH) |-> (!out_valid_q || !out_stall))
		else $error("result overwritten before transfer");

endmodule

/* hw/rtl/first_fit_heap_allocator_top.sv */
// Top level of the first-fit free-list heap allocator.
// Depends on ffa_pkg, ffa_ctrl and ffa_dp (which holds ffa_mem).
//
//  channel  direction  handshake            payload
//  request  in         in_valid / in_stall  cmd, request_size, block_addr
//  result   out        out_valid/out_stall  payload_offset, status, free_bytes,
//                                           free_nodes
//  config   in         cfg_we               cfg_wdata (magic word)
//
// One request at a time; each 64-bit header access is byte serial over the
// heap byte array. Allocate walks the free list from the head and splits
// the first node that fits, relinking its predecessor unless that node is
// the head. Free pushes the block at the head and merges each adjacent
// successor; refused frees end sooner. After reset a clearing pass over
// every heap byte rebuilds the heap image and requests are held off.
// A stalled result holds the next one in the datapath.
module first_fit_heap_allocator_top #(
	parameter int HEAP_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [12:0] request_size,
	input  logic [11:0] block_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] payload_offset,
	output logic [1:0]  status,
	output logic [12:0] free_bytes,
	output logic [8:0]  free_nodes,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata
);

	localparam int HW = $clog2(HEAP_BYTES);
	localparam int AW = ((HW > 13) ? HW : 13) + 2;
	localparam int SW = $clog2(HEAP_BYTES / HEADER_BYTES + 2);

	ffa_pkg::ctl_t ctl;
	ffa_pkg::sts_t sts;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	ffa_dp #(
		.HEAP_BYTES  (HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.AW          (AW),
		.SW          (SW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.cmd           (cmd),
		.request_size  (request_size),
		.block_addr    (block_addr),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.payload_offset(payload_offset),
		.status        (status),
		.free_bytes    (free_bytes),
		.free_nodes    (free_nodes)
	);

endmodule

/* dv/first_fit_heap_allocator_top_tb.sv */
// Self-checking testbench for first_fit_heap_allocator_top.
// Depends on ffa_pkg and the allocator RTL. It keeps its own image of the heap
// and free list, so every result is checked against a first-fit prediction.
`timescale 1ns / 100ps

module first_fit_heap_allocator_top_tb;

	localparam int HEAP   = 4096;
	localparam int HDR    = 16;
	localparam int WALK_MAX = HEAP / HDR + 1;
	localparam logic [63:0] LIST_END = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 60000;

	typedef struct {
		logic        op;
		logic [12:0] req_size;
		logic [11:0] addr;
	} heap_req_t;

	typedef struct {
		logic [11:0]      payload;
		ffa_pkg::status_t stat;
		logic [12:0]      fbytes;
		logic [8:0]       fnodes;
	} heap_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        cmd;
	logic [12:0] request_size;
	logic [11:0] block_addr;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] payload_offset;
	logic [1:0]  status;
	logic [12:0] free_bytes;
	logic [8:0]  free_nodes;
	logic        cfg_we;
	logic [63:0] cfg_wdata;

	first_fit_heap_allocator_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .request_size(request_size), .block_addr(block_addr),
		.out_valid(out_valid), .out_stall(out_stall),
		.payload_offset(payload_offset), .status(status),
		.free_bytes(free_bytes), .free_nodes(free_nodes),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// shadow allocator state
	logic [7:0]  heap_img [HEAP];
	logic [63:0] list_head, free_sum, free_cnt, magic_val;

	heap_req_t   pending_reqs [$];
	heap_res_t   expected_res [$];
	logic [11:0] live_blocks [$];

	int errors = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_reqs = 0;
	int holds_done = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	int n_alloc_ok = 0, n_nofit = 0, n_free_ok = 0, n_bad = 0, n_results = 0;
	logic req_fire = 1'b0;

	always #10 clk = ~clk;

	function automatic logic [63:0] heap_rd(logic [63:0] off);
		logic [63:0] v, a;
		v = '0;
		for (int i = 0; i < 8; i++) begin
			a = off + 64'(i);
			if (a >= off && a < 64'(HEAP))
				v |= 64'(heap_img[a]) << (8 * i);
		end
		return v;
	endfunction

	function automatic void heap_wr(logic [63:0] off, logic [63:0] v);
		logic [63:0] a;
		for (int i = 0; i < 8; i++) begin
			a = off + 64'(i);
			if (a >= off && a < 64'(HEAP))
				heap_img[a] = v[8*i +: 8];
		end
	endfunction

	function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	// first fit: returns status, payload through pay
	function automatic ffa_pkg::status_t carve_block(logic [63:0] req,
		output logic [63:0] pay);
		logic [63:0] prev, cur, need, sz, nxt, rem;
		int steps;
		prev = LIST_END;
		cur = list_head;
		need = req + 64'(HDR);
		steps = 0;
		pay = '0;
		while (cur < 64'(HEAP) && steps < WALK_MAX) begin
			sz = heap_rd(cur);
			if (sz >= need) begin
				nxt = heap_rd(cur + 64'd8);
				rem = cur + need;
				heap_wr(rem, sz - need);
				heap_wr(rem + 64'd8, nxt);
				if (prev == LIST_END)
					list_head = rem;
				else
					heap_wr(prev + 64'd8, rem);
				heap_wr(cur, req);
				heap_wr(cur + 64'd8, magic_val);
				free_sum = sub_sat(free_sum, need);
				pay = cur + 64'(HDR);
				return ffa_pkg::ST_OK;
			end
			prev = cur;
			cur = heap_rd(cur + 64'd8);
			steps++;
		end
		return ffa_pkg::ST_NOFIT;
	endfunction

	// push to head, then merge with adjacent successors
	function automatic ffa_pkg::status_t release_block(logic [63:0] addr);
		logic [63:0] hdr, sz, cur, nxt, csz;
		int steps;
		if (addr < 64'(HDR))
			return ffa_pkg::ST_BAD;
		hdr = addr - 64'(HDR);
		if (heap_rd(hdr + 64'd8) != magic_val)
			return ffa_pkg::ST_BAD;
		sz = heap_rd(hdr);
		if (addr > 64'(HEAP) || sz > 64'(HEAP) - addr)
			return ffa_pkg::ST_BAD;
		heap_wr(hdr + 64'd8, list_head);
		free_sum += sz;
		free_cnt += 64'd1;
		cur = hdr;
		steps = 0;
		while (steps < WALK_MAX) begin
			nxt = heap_rd(cur + 64'd8);
			if (nxt >= 64'(HEAP))
				break;
			csz = heap_rd(cur);
			if (nxt != cur + csz + 64'(HDR))
				break;
			heap_wr(cur, csz + 64'(HDR) + heap_rd(nxt));
			heap_wr(cur + 64'd8, heap_rd(nxt + 64'd8));
			free_sum += 64'(HDR);
			free_cnt = sub_sat(free_cnt, 64'd1);
			steps++;
		end
		list_head = hdr;
		return ffa_pkg::ST_OK;
	endfunction

	// predict one request and queue it with its expected result
	task automatic post_req(logic op, logic [12:0] rs, logic [11:0] ba);
		heap_req_t r;
		heap_res_t e;
		logic [63:0] pay;
		r.op = op;
		r.req_size = rs;
		r.addr = ba;
		pay = '0;
		if (op == ffa_pkg::CMD_ALLOC)
			e.stat = carve_block(64'(rs), pay);
		else
			e.stat = release_block(64'(ba));
		e.payload = pay[11:0];
		e.fbytes = free_sum[12:0];
		e.fnodes = free_cnt[8:0];
		if (op == ffa_pkg::CMD_ALLOC && e.stat == ffa_pkg::ST_OK)
			live_blocks.push_back(pay[11:0]);
		pending_reqs.push_back(r);
		expected_res.push_back(e);
	endtask

	task automatic free_live(int idx);
		logic [11:0] a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		post_req(ffa_pkg::CMD_FREE, 13'($urandom), a);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_res.size() != 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_magic(logic [63:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		magic_val = v;
	endtask

	// mostly well-formed alloc/free traffic with some stray and oversize requests
	task automatic random_traffic(int n);
		int r;
		logic [11:0] last_freed;
		last_freed = 12'd16;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (live_blocks.size() > 48)
				r = 60;
			if (r < 40)
				post_req(ffa_pkg::CMD_ALLOC, 13'($urandom_range(0, 96)), 12'($urandom));
			else if (r < 44)
				post_req(ffa_pkg::CMD_ALLOC, 13'($urandom_range(0, 8191)), 12'($urandom));
			else if (r < 48)
				post_req(ffa_pkg::CMD_ALLOC, 13'($urandom_range(1000, 4096)),
					12'($urandom));
			else if (r < 90 && live_blocks.size() != 0) begin
				last_freed = live_blocks[0];
				free_live($urandom_range(0, live_blocks.size() - 1));
			end else if (r < 95)
				post_req(ffa_pkg::CMD_FREE, 13'($urandom), 12'($urandom));
			else
				post_req(ffa_pkg::CMD_FREE, 13'($urandom), last_freed);
		end
	endtask

	task automatic free_all_live();
		while (live_blocks.size() != 0)
			free_live(0);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!in_valid || req_fire) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				heap_req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				cmd <= r.op;
				request_size <= r.req_size;
				block_addr <= r.addr;
			end else
				in_valid <= 1'b0;
		end
	end

	// result receiver stall, with long hold-offs on request
	always @(negedge clk) begin
		if (hold_left == 0 && holds_done < hold_reqs) begin
			holds_done++;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// transfer monitor and checker
	always @(posedge clk) begin
		req_fire <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (expected_res.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: off=%0d st=%0d fb=%0d fn=%0d",
					$time, payload_offset, status, free_bytes, free_nodes);
			end else begin
				heap_res_t e;
				e = expected_res.pop_front();
				if (payload_offset !== e.payload) begin
					errors++;
					$display("%0t: payload_offset exp %0d got %0d", $time, e.payload,
						payload_offset);
				end
				if (status !== e.stat) begin
					errors++;
					$display("%0t: status exp %0d got %0d", $time, e.stat, status);
				end
				if (free_bytes !== e.fbytes) begin
					errors++;
					$display("%0t: free_bytes exp %0d got %0d", $time, e.fbytes, free_bytes);
				end
				if (free_nodes !== e.fnodes) begin
					errors++;
					$display("%0t: free_nodes exp %0d got %0d", $time, e.fnodes, free_nodes);
				end
				case (e.stat)
					ffa_pkg::ST_OK: if (payload_offset != 0) n_alloc_ok++; else n_free_ok++;
					ffa_pkg::ST_NOFIT: n_nofit++;
					default: n_bad++;
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("first_fit_heap_allocator_top_tb: done, errors");
			$finish;
		end
	end

	initial begin
		logic [63:0] seg_magic [6];
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = ffa_pkg::CMD_ALLOC;
		request_size = '0;
		block_addr = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;

		// shadow reset image
		for (int i = 0; i < HEAP; i++)
			heap_img[i] = 8'h00;
		heap_wr(64'd0, 64'(HEAP - HDR));
		heap_wr(64'd8, LIST_END);
		list_head = '0;
		free_sum = 64'(HEAP - HDR);
		free_cnt = 64'd1;
		magic_val = ffa_pkg::MAGIC_RESET;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, exact fit, bad frees, double free, merges
		tx_idle_pct = 32;
		rx_idle_pct = 76;
		post_req(ffa_pkg::CMD_ALLOC, 13'd4096, 12'hFFF);
		post_req(ffa_pkg::CMD_ALLOC, 13'd8191, 12'd0);
		post_req(ffa_pkg::CMD_ALLOC, 13'd4080, 12'd0);
		post_req(ffa_pkg::CMD_ALLOC, 13'd4064, 12'd0);
		post_req(ffa_pkg::CMD_ALLOC, 13'd0, 12'd0);
		free_live(0);
		post_req(ffa_pkg::CMD_ALLOC, 13'd0, 12'd0);
		post_req(ffa_pkg::CMD_ALLOC, 13'd32, 12'd0);
		post_req(ffa_pkg::CMD_ALLOC, 13'd100, 12'd0);
		post_req(ffa_pkg::CMD_FREE, 13'h1FFF, 12'd0);
		post_req(ffa_pkg::CMD_FREE, 13'd0, 12'd15);
		post_req(ffa_pkg::CMD_FREE, 13'd0, 12'hFFF);
		post_req(ffa_pkg::CMD_FREE, 13'd0, 12'd16);
		post_req(ffa_pkg::CMD_FREE, 13'd0, 12'd16);
		free_all_live();
		post_req(ffa_pkg::CMD_ALLOC, 13'd1, 12'd0);
		post_req(ffa_pkg::CMD_ALLOC, 13'd7, 12'd0);
		free_all_live();
		wait_drained();

		seg_magic[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		seg_magic[1] = 64'd0;
		seg_magic[2] = {$urandom, $urandom};
		seg_magic[3] = ffa_pkg::MAGIC_RESET;
		seg_magic[4] = {$urandom, $urandom};
		seg_magic[5] = 64'hFFFF_FFFF_FFFF_FFFF;

		for (int s = 0; s < 6; s++) begin
			tx_idle_pct = (s < 2) ? 32 : (s < 4) ? 76 : 0;
			rx_idle_pct = (s < 2) ? 76 : (s < 4) ? 32 : 0;
			write_magic(seg_magic[s]);
			random_traffic(110);
			// receiver holds off long while requests keep coming
			if (s == 2 || s == 4)
				hold_reqs++;
			// sender pause until every result is back
			wait_drained();
			random_traffic(110);
			free_all_live();
			wait_drained();
		end

		repeat (200) @(posedge clk);
		$display("covered %0d results: %0d allocs ok, %0d no fit, %0d frees ok, %0d refused",
			n_results, n_alloc_ok, n_nofit, n_free_ok, n_bad);
		$display("six magic word settings, extremes included, under three idling patterns");
		if (errors == 0)
			$display("first_fit_heap_allocator_top_tb: done, clean");
		else
			$display("first_fit_heap_allocator_top_tb: done, errors");
		$finish;
	end

endmodule
